// ----- hw/rtl/kepler_pkg.sv -----
// kepler_pkg: types, constants and the cordic arctangent table for the
// kepler equation newton solver; no dependencies
package kepler_pkg;

    localparam int MAX_STEPS = 64;
    localparam int CORDIC_N  = 30;
    localparam int DIV_BITS  = 64;

    // q.30 angle constants, 35-bit signed, and the 34-bit cordic gain
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;

    // configuration register indexes
    localparam logic REG_TOL = 1'b0;
    localparam logic REG_MIN = 1'b1;

    typedef struct packed {
        logic signed [31:0] mean_anom;
        logic [30:0]        ecc;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] ecc_anom;
        logic [6:0]         steps_taken;
        logic               not_converged;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED0,
        ST_RED1,
        ST_RED2,
        ST_CORD,
        ST_MULS,
        ST_FCALC,
        ST_DEN,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } state_t;

    // arctangent table in q2.30
    function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
        logic signed [34:0] v;
        unique case (i)
            5'd0:  v = 35'sd843314857;
            5'd1:  v = 35'sd497837829;
            5'd2:  v = 35'sd263043837;
            5'd3:  v = 35'sd133525159;
            5'd4:  v = 35'sd67021687;
            5'd5:  v = 35'sd33543516;
            5'd6:  v = 35'sd16775851;
            5'd7:  v = 35'sd8388437;
            5'd8:  v = 35'sd4194283;
            5'd9:  v = 35'sd2097149;
            5'd10: v = 35'sd1048576;
            5'd11: v = 35'sd524288;
            5'd12: v = 35'sd262144;
            5'd13: v = 35'sd131072;
            5'd14: v = 35'sd65536;
            5'd15: v = 35'sd32768;
            5'd16: v = 35'sd16384;
            5'd17: v = 35'sd8192;
            5'd18: v = 35'sd4096;
            5'd19: v = 35'sd2048;
            5'd20: v = 35'sd1024;
            5'd21: v = 35'sd512;
            5'd22: v = 35'sd256;
            5'd23: v = 35'sd128;
            5'd24: v = 35'sd64;
            5'd25: v = 35'sd32;
            5'd26: v = 35'sd16;
            5'd27: v = 35'sd8;
            5'd28: v = 35'sd4;
            5'd29: v = 35'sd2;
            default: v = 35'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/kepler_equation_newton_solver.sv -----
// kepler_equation_newton_solver: newton solver for M = E - e*sin(E)
// depends on kepler_pkg
//
//  channel  | ports                     | dir | beat
//  ---------+---------------------------+-----+-----------------------------
//  input    | s_valid s_ready s_data    | in  | mean_anom, ecc
//  result   | m_valid m_ready m_data    | out | ecc_anom, steps_taken, flag
//  config   | psel penable pwrite paddr | in  | tolerance_lsb @0, min_iter @4
//
// one newton step runs angle reduction (RED0, RED1 and RED2), 30 cordic
// iterations, the two products and the denominator (MULS, FCALC, DEN), the
// 64-bit one-bit-per-cycle restoring divider, then one update state. the
// reset minimum is 15 steps per item.
// s_ready is low while an item is in work; a finished result sits in the
// output register so the next beat can be taken while it waits.
// reset is synchronous active low and restores the register defaults.
module kepler_equation_newton_solver (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kepler_pkg::in_beat_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kepler_pkg::out_beat_t m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    kepler_pkg::state_t state_reg, state_next;

    logic [15:0]        tol_reg;
    logic [6:0]         min_reg;
    logic signed [31:0] m_reg, m_next;
    logic [30:0]        ecc_reg, ecc_next;
    logic signed [31:0] e_reg, e_next;
    logic signed [34:0] r_reg, r_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [34:0] z_reg, z_next;
    logic [5:0]         it_reg, it_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [34:0] f_reg, f_next;
    logic [31:0]        den_reg, den_next;
    logic [31:0]        rem_reg, rem_next;
    logic [63:0]        mag_reg, mag_next;
    logic [6:0]         j_reg, j_next;
    logic               m_valid_reg;
    kepler_pkg::out_beat_t out_reg, res_reg, res_next;

    // shared datapath signals
    logic signed [33:0] mul_b, c_val, dx, dy;
    logic signed [65:0] mul_p;
    logic signed [34:0] a4;
    logic signed [35:0] den_w;
    logic [33:0]        f_abs;
    logic [32:0]        trial;
    logic               take;
    logic [63:0]        q_sat;
    logic signed [35:0] e_sum;
    logic signed [31:0] e_new;
    logic signed [33:0] err_s;
    logic [33:0]        err_abs;
    logic [6:0]         j_inc;
    logic               err_big, open_w, cont_w, out_free, wr_en;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == kepler_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign wr_en   = psel && penable && pwrite;
    assign prdata  = (paddr[2] == kepler_pkg::REG_MIN) ? {25'd0, min_reg}
                                                       : {16'd0, tol_reg};
    assign out_free = !m_valid_reg || m_ready;

    // shared multiplier, cordic shifter, divider trial and update math
    assign c_val = flip_reg ? -x_reg : x_reg;
    assign mul_b = (state_reg == kepler_pkg::ST_MULS) ? y_reg : c_val;
    assign mul_p = $signed({1'b0, ecc_reg}) * mul_b;
    assign a4    = {e_reg[31], e_reg, 2'b00};
    assign dx    = y_reg >>> it_reg[4:0];
    assign dy    = x_reg >>> it_reg[4:0];
    assign den_w = 36'sd1073741824 - 36'($signed(prod_reg[65:31]));
    assign f_abs = f_reg[34] ? 34'(-f_reg) : f_reg[33:0];
    assign trial = {rem_reg, mag_reg[63]};
    assign take  = (trial >= {1'b0, den_reg});
    assign q_sat = (mag_reg > 64'h2_0000_0000) ? 64'h2_0000_0000 : mag_reg;
    assign e_sum = f_reg[34] ? (36'(e_reg) + $signed({1'b0, q_sat[34:0]}))
                             : (36'(e_reg) - $signed({1'b0, q_sat[34:0]}));
    assign e_new = (e_sum > 36'sd2147483647)  ? 32'sh7fffffff :
                   (e_sum < -36'sd2147483648) ? 32'sh80000000 : e_sum[31:0];
    assign err_s   = 34'(e_new) - 34'(e_reg);
    assign err_abs = err_s[33] ? -err_s : err_s;
    assign err_big = (err_abs > {18'd0, tol_reg});
    assign j_inc   = j_reg + 7'd1;
    assign open_w  = err_big || (j_inc < min_reg);
    assign cont_w  = open_w && (j_inc < 7'(kepler_pkg::MAX_STEPS));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kepler_pkg::ST_IDLE:  if (s_valid) state_next = kepler_pkg::ST_RED0;
            kepler_pkg::ST_RED0:  state_next = kepler_pkg::ST_RED1;
            kepler_pkg::ST_RED1:  state_next = kepler_pkg::ST_RED2;
            kepler_pkg::ST_RED2:  state_next = kepler_pkg::ST_CORD;
            kepler_pkg::ST_CORD: begin
                if (it_reg == 6'(kepler_pkg::CORDIC_N - 1)) state_next = kepler_pkg::ST_MULS;
            end
            kepler_pkg::ST_MULS:  state_next = kepler_pkg::ST_FCALC;
            kepler_pkg::ST_FCALC: state_next = kepler_pkg::ST_DEN;
            kepler_pkg::ST_DEN:   state_next = kepler_pkg::ST_DIV;
            kepler_pkg::ST_DIV: begin
                if (it_reg == 6'(kepler_pkg::DIV_BITS - 1)) state_next = kepler_pkg::ST_UPD;
            end
            kepler_pkg::ST_UPD: begin
                state_next = cont_w ? kepler_pkg::ST_RED0 : kepler_pkg::ST_DONE;
            end
            kepler_pkg::ST_DONE:  if (out_free) state_next = kepler_pkg::ST_IDLE;
            default:              state_next = kepler_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        m_next    = m_reg;
        ecc_next  = ecc_reg;
        e_next    = e_reg;
        r_next    = r_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        it_next   = it_reg;
        prod_next = prod_reg;
        f_next    = f_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        mag_next  = mag_reg;
        j_next    = j_reg;
        res_next  = res_reg;
        unique case (state_reg)
            kepler_pkg::ST_IDLE: begin
                m_next   = s_data.mean_anom;
                ecc_next = s_data.ecc;
                e_next   = s_data.mean_anom;
                j_next   = 7'd0;
            end
            // truncating remainder by two pi
            kepler_pkg::ST_RED0: begin
                if (a4 >= kepler_pkg::TWO_PI_Q30)       r_next = a4 - kepler_pkg::TWO_PI_Q30;
                else if (a4 <= -kepler_pkg::TWO_PI_Q30) r_next = a4 + kepler_pkg::TWO_PI_Q30;
                else                                    r_next = a4;
            end
            // wrap into [-pi, pi]
            kepler_pkg::ST_RED1: begin
                if (r_reg > kepler_pkg::PI_Q30)       r_next = r_reg - kepler_pkg::TWO_PI_Q30;
                else if (r_reg < -kepler_pkg::PI_Q30) r_next = r_reg + kepler_pkg::TWO_PI_Q30;
            end
            // fold into [-pi/2, pi/2] and seed the cordic
            kepler_pkg::ST_RED2: begin
                flip_next = 1'b0;
                z_next    = r_reg;
                if (r_reg > kepler_pkg::HALF_PI_Q30) begin
                    z_next    = kepler_pkg::PI_Q30 - r_reg;
                    flip_next = 1'b1;
                end else if (r_reg < -kepler_pkg::HALF_PI_Q30) begin
                    z_next    = -kepler_pkg::PI_Q30 - r_reg;
                    flip_next = 1'b1;
                end
                x_next  = kepler_pkg::CORDIC_K;
                y_next  = 34'sd0;
                it_next = 6'd0;
            end
            // one cordic rotation per cycle
            kepler_pkg::ST_CORD: begin
                if (!z_reg[34]) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - kepler_pkg::atan_q30(it_reg[4:0]);
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + kepler_pkg::atan_q30(it_reg[4:0]);
                end
                it_next = it_reg + 6'd1;
            end
            kepler_pkg::ST_MULS: prod_next = mul_p;
            // residual, and e*cos on the shared multiplier
            kepler_pkg::ST_FCALC: begin
                f_next    = 35'(e_reg) - 35'($signed(prod_reg[65:33])) - 35'(m_reg);
                prod_next = mul_p;
            end
            // denominator and divider setup
            kepler_pkg::ST_DEN: begin
                den_next = (den_w <= 36'sd0) ? 32'd1 : den_w[31:0];
                mag_next = {f_abs, 30'd0};
                rem_next = 32'd0;
                it_next  = 6'd0;
            end
            // restoring divide, one quotient bit per cycle
            kepler_pkg::ST_DIV: begin
                rem_next = take ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                mag_next = {mag_reg[62:0], take};
                it_next  = it_reg + 6'd1;
            end
            kepler_pkg::ST_UPD: begin
                j_next = j_inc;
                if (cont_w) begin
                    e_next = e_new;
                end else begin
                    res_next.ecc_anom      = e_reg;
                    res_next.steps_taken   = j_inc;
                    res_next.not_converged = err_big;
                end
            end
            kepler_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kepler_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            tol_reg     <= 16'd1;
            min_reg     <= 7'd15;
        end else begin
            state_reg <= state_next;
            if (state_reg == kepler_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                if (paddr[2] == kepler_pkg::REG_MIN) min_reg <= pwdata[6:0];
                else                                 tol_reg <= pwdata[15:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_reg    <= m_next;
        ecc_reg  <= ecc_next;
        e_reg    <= e_next;
        r_reg    <= r_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        it_reg   <= it_next;
        prod_reg <= prod_next;
        f_reg    <= f_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        mag_reg  <= mag_next;
        j_reg    <= j_next;
        res_reg  <= res_next;
        if (state_reg == kepler_pkg::ST_DONE && out_free) out_reg <= res_reg;
    end

endmodule

// ----- dv/kepler_solution_checker.sv -----
// kepler_solution_checker: watches the input, result and register ports of the
// kepler equation newton solver, predicts each result and compares it
// depends on kepler_pkg
module kepler_solution_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  kepler_pkg::in_beat_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  kepler_pkg::out_beat_t m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    results_owed
);

    localparam longint ONE_Q30     = 64'sd1 <<< 30;
    localparam longint HALF_PI     = 64'sd1686629713;
    localparam longint PI_VAL      = 64'sd3373259426;
    localparam longint TWO_PI      = 64'sd6746518852;
    localparam longint GAIN_START  = 64'sd652032874;
    localparam longint STEP_CAP    = 64'sd1 <<< 33;

    localparam longint ARCTAN [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2
    };

    logic [15:0]           tol_lsb;
    logic [6:0]            min_steps;
    kepler_pkg::out_beat_t anomaly_q[$];

    assign results_owed = anomaly_q.size();

    // rotation cordic on the reduced angle, q.30 sine and cosine
    function automatic void rotate_sincos(input longint ang, output longint sn,
                                          output longint cs);
        longint r, x, y, z, dx, dy;
        bit flip;
        r = (ang * 4) % TWO_PI;
        flip = 0;
        if (r > PI_VAL) r -= TWO_PI;
        if (r < -PI_VAL) r += TWO_PI;
        if (r > HALF_PI) begin
            r = PI_VAL - r;
            flip = 1;
        end else if (r < -HALF_PI) begin
            r = -PI_VAL - r;
            flip = 1;
        end
        x = GAIN_START;
        y = 0;
        z = r;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARCTAN[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARCTAN[i];
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endfunction

    // one newton update of the eccentric anomaly
    function automatic longint newton_update(input longint e_cur, input longint m,
                                             input longint ecc);
        longint sn, cs, f, den, delta, nxt;
        longint unsigned mag, q;
        rotate_sincos(e_cur, sn, cs);
        f = e_cur - ((ecc * sn) >>> 33) - m;
        den = ONE_Q30 - ((ecc * cs) >>> 31);
        if (den <= 0) den = 1;
        mag = longint'(f < 0 ? -f : f);
        mag = mag << 30;
        q = mag / longint'(den);
        if (q > STEP_CAP) q = STEP_CAP;
        delta = f < 0 ? -longint'(q) : longint'(q);
        nxt = e_cur - delta;
        if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
        if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
        return nxt;
    endfunction

    // full solve with the current tolerance and minimum step count
    function automatic kepler_pkg::out_beat_t solve_anomaly(input kepler_pkg::in_beat_t b);
        kepler_pkg::out_beat_t r;
        longint m, ecc, held, nxt, err;
        int j;
        bit open;
        m = longint'(b.mean_anom);
        ecc = longint'(b.ecc);
        nxt = m;
        j = 0;
        do begin
            j++;
            held = nxt;
            nxt = newton_update(held, m, ecc);
            err = nxt - held;
            if (err < 0) err = -err;
            open = (err > longint'(tol_lsb)) || (j < int'(min_steps));
        end while (open && j < kepler_pkg::MAX_STEPS);
        r.ecc_anom = held[31:0];
        r.steps_taken = j[6:0];
        r.not_converged = open && (err > longint'(tol_lsb));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    // register shadow, prediction on input beats, comparison on result beats
    always @(posedge aclk) begin
        kepler_pkg::out_beat_t want;
        if (!aresetn) begin
            tol_lsb <= 16'd1;
            min_steps <= 7'd15;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == kepler_pkg::REG_TOL) tol_lsb <= pwdata[15:0];
                else min_steps <= pwdata[6:0];
            end
            if (s_valid && s_ready) anomaly_q.push_back(solve_anomaly(s_data));
            if (m_valid && m_ready) begin
                if (anomaly_q.size() == 0) begin
                    report_mismatch("unexpected result beat", m_data.ecc_anom, 0);
                end else begin
                    want = anomaly_q.pop_front();
                    if (m_data.ecc_anom !== want.ecc_anom)
                        report_mismatch("ecc_anom", m_data.ecc_anom, want.ecc_anom);
                    if (m_data.steps_taken !== want.steps_taken)
                        report_mismatch("steps_taken", m_data.steps_taken,
                                        want.steps_taken);
                    if (m_data.not_converged !== want.not_converged)
                        report_mismatch("not_converged", m_data.not_converged,
                                        want.not_converged);
                end
            end
        end
    end

endmodule

// ----- dv/kepler_equation_newton_solver_tb.sv -----
// kepler_equation_newton_solver_tb: drives anomaly beats and register writes
// into the solver; depends on kepler_pkg and kepler_solution_checker
module kepler_equation_newton_solver_tb;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_valid = 0;
    logic                  s_ready;
    kepler_pkg::in_beat_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 0;
    kepler_pkg::out_beat_t m_data;
    logic                  psel = 0;
    logic                  penable = 0;
    logic                  pwrite = 0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    int                    fail_count;
    int                    results_owed;
    bit                    quiet = 0;
    bit                    long_hold = 0;

    always #6 aclk = ~aclk;

    kepler_equation_newton_solver DUT (.*);

    kepler_solution_checker u_checker (.*);

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            if (long_hold) begin
                m_ready <= 0;
                repeat (8000) @(negedge aclk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end else begin
                m_ready <= 1;
                @(negedge aclk);
            end
        end
    end

    task automatic send_beat(input kepler_pkg::in_beat_t b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= b;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        @(negedge aclk);
    endtask

    // register write, setup then access
    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 0;
        @(negedge aclk);
        while (results_owed != 0) @(negedge aclk);
    endtask

    task automatic send_item(input logic [31:0] m, input logic [30:0] e);
        kepler_pkg::in_beat_t b;
        b.mean_anom = m;
        b.ecc = e;
        send_beat(b);
    endtask

    // mostly orbit-range angles, some full range; eccentricity often near one
    task automatic send_random();
        logic [31:0] m;
        logic [30:0] e;
        m = $urandom;
        if ($urandom_range(0, 3) != 0) m = $signed(m) >>> $urandom_range(1, 4);
        case ($urandom_range(0, 4))
            0:       e = 31'(32'h7fffffff - $urandom_range(0, 100000));
            1:       e = 31'($urandom_range(0, 65535));
            default: e = 31'($urandom);
        endcase
        send_item(m, e);
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // reset settings: field extremes and awkward angles
        send_item(32'h0, 31'h0);
        send_item(32'h0, 31'h7fffffff);
        send_item(32'h1, 31'h7fffffff);
        send_item(32'hffffffff, 31'h7fffffff);
        send_item(32'h7fffffff, 31'h0);
        send_item(32'h80000000, 31'h0);
        send_item(32'h7fffffff, 31'h7fffffff);
        send_item(32'h80000000, 31'h7fffffff);
        send_item(32'h3243f6a8, 31'h40000000);
        send_item(32'hcdbc0958, 31'h7ffffff0);
        send_item(32'h1921fb54, 31'h1);
        send_item(32'h12345678, 31'h55555555);
        send_item(32'hedcba987, 31'h2aaaaaaa);
        send_item(32'h00000100, 31'h7fff0000);
        drain_results();

        // loosest tolerance, single step minimum
        write_reg(kepler_pkg::REG_TOL, 32'd65535);
        write_reg(kepler_pkg::REG_MIN, 32'd1);
        repeat (40) send_random();
        drain_results();

        // tightest tolerance with the minimum at the cap
        write_reg(kepler_pkg::REG_TOL, 32'd0);
        write_reg(kepler_pkg::REG_MIN, 32'd64);
        repeat (8) send_random();
        drain_results();

        // zero minimum still takes one step
        write_reg(kepler_pkg::REG_MIN, 32'd0);
        repeat (10) send_random();
        drain_results();

        // minimum above the cap
        write_reg(kepler_pkg::REG_TOL, 32'd37);
        write_reg(kepler_pkg::REG_MIN, 32'd127);
        repeat (8) send_random();
        drain_results();

        // main random phases
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(kepler_pkg::REG_TOL, $urandom_range(0, 65535));
            write_reg(kepler_pkg::REG_MIN, $urandom_range(1, 5));
            if (ph == 2) long_hold = 1;
            if (ph == 8) quiet = 1;
            repeat (50) send_random();
            drain_results();
        end

        repeat (200) @(negedge aclk);
        if (fail_count == 0) $display("** kepler_equation_newton_solver: PASSED **");
        else $display("** kepler_equation_newton_solver: FAILED **");
        $finish;
    end

    // timeout
    initial begin
        #(12 * 30000000);
        $display("** kepler_equation_newton_solver: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/kepler_pkg.sv
hw/rtl/kepler_equation_newton_solver.sv
dv/kepler_solution_checker.sv
dv/kepler_equation_newton_solver_tb.sv
